// File: rtl/core/pcipm_pkg.sv
// Shared types, codes and constants of the PM function configuration space.
`default_nettype none
package pcipm_pkg;

    typedef enum logic [1:0] {
        MODE_CFG_RD = 2'd0,
        MODE_CFG_WR = 2'd1,
        MODE_IO_RD  = 2'd2,
        MODE_IO_WR  = 2'd3
    } t_mode;

    localparam logic [1:0] SIZE_BYTE = 2'd0;
    localparam logic [1:0] SIZE_HALF = 2'd1;
    localparam logic [1:0] SIZE_WORD = 2'd2;
    localparam logic [1:0] SIZE_ALT  = 2'd3;

    localparam logic [15:0] VENDOR_ID  = 16'h8086;
    localparam logic [15:0] DEVICE_ID  = 16'h7113;
    localparam logic [7:0]  CLASS_BASE = 8'h06;
    localparam logic [7:0]  CLASS_SUB  = 8'h80;
    localparam logic [7:0]  INT_PIN    = 8'h01;
    localparam logic [15:0] CMD_MASK   = 16'h021F;
    localparam logic [15:0] PMBA_MASK  = 16'hFFC0;
    localparam logic [15:0] SMBBA_MASK = 16'hFFF0;
    localparam logic [16:0] PM_SPAN    = 17'h00038;
    localparam logic [16:0] SMB_SPAN   = 17'h0000E;
    localparam logic [16:0] PMTMR_OFS  = 17'h00008;

    // Config register indexes, each in units of its access size
    localparam logic [7:0] A8_INT_LINE  = 8'h3C;
    localparam logic [7:0] A8_INT_PIN   = 8'h3D;
    localparam logic [7:0] A8_PM_EN     = 8'h80;
    localparam logic [7:0] A8_SMB_HCFG  = 8'hD2;
    localparam logic [7:0] A16_COMMAND  = 8'h02;
    localparam logic [7:0] A32_PM_BASE  = 8'h10;
    localparam logic [7:0] A32_SMB_BASE = 8'h24;

    typedef struct packed {
        logic [15:0] command_reg;
        logic [7:0]  interrupt_line;
        logic        pm_io_enable;
        logic [15:0] pm_base;
        logic [15:0] smbus_base;
        logic [7:0]  smbus_host_cfg;
    } t_reg_state;

    typedef struct packed {
        logic        we_command;
        logic        we_int_line;
        logic        we_pm_en;
        logic        we_pm_base;
        logic        we_smb_base;
        logic        we_smb_hcfg;
        logic [31:0] data;
    } t_reg_wr;

endpackage
`default_nettype wire

// File: rtl/core/pcipm_regs.sv
// Stored configuration registers with masked writes.
`default_nettype none
module pcipm_regs
    import pcipm_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_commit,
    input  wire t_reg_wr    i_wr,
    output t_reg_state      o_state
);

    t_reg_state r_state;
    t_reg_state n_state;

    always_comb begin
        n_state = r_state;
        if (i_commit) begin
            if (i_wr.we_command)  n_state.command_reg    = i_wr.data[15:0] & CMD_MASK;
            if (i_wr.we_int_line) n_state.interrupt_line = i_wr.data[7:0];
            if (i_wr.we_pm_en)    n_state.pm_io_enable   = i_wr.data[0];
            if (i_wr.we_pm_base)  n_state.pm_base        = i_wr.data[15:0] & PMBA_MASK;
            if (i_wr.we_smb_base) n_state.smbus_base     = i_wr.data[15:0] & SMBBA_MASK;
            if (i_wr.we_smb_hcfg) n_state.smbus_host_cfg = i_wr.data[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_state = r_state;

endmodule
`default_nettype wire

// File: rtl/core/pcipm_decode.sv
// Config and I/O address decode: read data, claim, flag and write strobes.
`default_nettype none
module pcipm_decode
    import pcipm_pkg::*;
(
    input  wire logic [1:0]  i_mode,
    input  wire logic [1:0]  i_size,
    input  wire logic [15:0] i_address,
    input  wire logic [31:0] i_write_data,
    input  wire logic [31:0] i_timer_value,
    input  wire t_reg_state  i_state,
    output logic [31:0]      o_read_data,
    output logic             o_claimed,
    output logic             o_unimplemented,
    output t_reg_wr          o_wr
);

    logic [1:0]  sz;
    logic [7:0]  a;
    logic        hi;
    logic [16:0] port;
    logic [16:0] pm_lo;
    logic [16:0] smb_lo;
    logic        in_pm;
    logic        in_smb;
    logic        ok;
    logic [31:0] rd;
    logic [31:0] ones;

    assign sz     = (i_size == SIZE_ALT) ? SIZE_WORD : i_size;
    assign a      = i_address[7:0];
    assign hi     = |i_address[15:8];
    assign port   = {1'b0, i_address};
    assign pm_lo  = {1'b0, i_state.pm_base};
    assign smb_lo = {1'b0, i_state.smbus_base};
    assign in_pm  = i_state.pm_io_enable && (port >= pm_lo) && (port < pm_lo + PM_SPAN);
    assign in_smb = i_state.command_reg[0] && (port >= smb_lo) && (port < smb_lo + SMB_SPAN);

    always_comb begin
        case (sz)
            SIZE_BYTE: ones = 32'h0000_00FF;
            SIZE_HALF: ones = 32'h0000_FFFF;
            default:   ones = 32'hFFFF_FFFF;
        endcase
    end

    always_comb begin
        rd                  = '0;
        ok                  = 1'b1;
        o_claimed           = 1'b0;
        o_wr                = '0;
        o_wr.data           = i_write_data;
        case (t_mode'(i_mode))
            MODE_CFG_RD: begin
                o_claimed = 1'b1;
                if (hi) begin
                    ok = 1'b0;
                    rd = ones;
                end else if (sz == SIZE_BYTE) begin
                    if (a <= 8'h01)       rd = {24'h0, a[0] ? VENDOR_ID[15:8] : VENDOR_ID[7:0]};
                    else if (a <= 8'h03)  rd = {24'h0, a[0] ? DEVICE_ID[15:8] : DEVICE_ID[7:0]};
                    else if (a == 8'h08 || a == 8'h09 || a == 8'h0E) rd = '0;
                    else if (a == 8'h0A)  rd = {24'h0, CLASS_SUB};
                    else if (a == 8'h0B)  rd = {24'h0, CLASS_BASE};
                    else if (a >= 8'h0F && a <= 8'h3B) rd = '0;
                    else if (a == A8_INT_LINE) rd = {24'h0, i_state.interrupt_line};
                    else if (a == A8_INT_PIN)  rd = {24'h0, INT_PIN};
                    else if (a == A8_PM_EN)    rd = {31'h0, i_state.pm_io_enable};
                    else if (a == A8_SMB_HCFG) rd = {24'h0, i_state.smbus_host_cfg};
                    else begin
                        ok = 1'b0;
                        rd = ones;
                    end
                end else if (sz == SIZE_HALF) begin
                    if (a == 8'h00)             rd = {16'h0, VENDOR_ID};
                    else if (a == 8'h01)        rd = {16'h0, DEVICE_ID};
                    else if (a == A16_COMMAND)  rd = {16'h0, i_state.command_reg};
                    else if (a == 8'h04)        rd = '0;
                    else if (a == 8'h05)        rd = {16'h0, CLASS_BASE, CLASS_SUB};
                    else if (a >= 8'h08 && a <= 8'h1D) rd = '0;
                    else begin
                        ok = 1'b0;
                        rd = ones;
                    end
                end else begin
                    if (a == 8'h00)              rd = {DEVICE_ID, VENDOR_ID};
                    else if (a == 8'h02)         rd = {CLASS_BASE, CLASS_SUB, 16'h0};
                    else if (a >= 8'h04 && a <= 8'h0E) rd = '0;
                    else if (a == A32_PM_BASE)   rd = {16'h0, i_state.pm_base[15:1], 1'b1};
                    else if (a == A32_SMB_BASE)  rd = {16'h0, i_state.smbus_base[15:1], 1'b1};
                    else begin
                        ok = 1'b0;
                        rd = ones;
                    end
                end
            end
            MODE_CFG_WR: begin
                o_claimed = 1'b1;
                if (hi) begin
                    ok = 1'b0;
                end else if (sz == SIZE_BYTE) begin
                    if (a <= 8'h03 || a == 8'h09 || a == 8'h0A || a == 8'h0B || a == 8'h0E ||
                        (a >= 8'h0F && a <= 8'h3B) || a == A8_INT_PIN) ok = 1'b1;
                    else if (a == A8_INT_LINE) o_wr.we_int_line = 1'b1;
                    else if (a == A8_PM_EN)    o_wr.we_pm_en    = 1'b1;
                    else if (a == A8_SMB_HCFG) o_wr.we_smb_hcfg = 1'b1;
                    else ok = 1'b0;
                end else if (sz == SIZE_HALF) begin
                    if (a == 8'h00 || a == 8'h01 || a == 8'h05 || (a >= 8'h08 && a <= 8'h1D))
                        ok = 1'b1;
                    else if (a == A16_COMMAND) o_wr.we_command = 1'b1;
                    else ok = 1'b0;
                end else begin
                    if (a == 8'h00 || (a >= 8'h04 && a <= 8'h0E)) ok = 1'b1;
                    else if (a == A32_PM_BASE)  o_wr.we_pm_base  = 1'b1;
                    else if (a == A32_SMB_BASE) o_wr.we_smb_base = 1'b1;
                    else ok = 1'b0;
                end
            end
            default: begin
                // PM window wins over the SMBus window
                if (in_pm) begin
                    o_claimed = 1'b1;
                    if (t_mode'(i_mode) == MODE_IO_RD && sz == SIZE_WORD &&
                        port == pm_lo + PMTMR_OFS) rd = i_timer_value;
                    else ok = 1'b0;
                end else if (in_smb) begin
                    o_claimed = 1'b1;
                    ok        = 1'b0;
                end
            end
        endcase
    end

    assign o_read_data     = rd;
    assign o_unimplemented = !ok;

endmodule
`default_nettype wire

// File: rtl/core/pci_pm_function_config_space_core.sv
// Top level: input register, decode and register file, result register.
//
// channel  dir  handshake                      payload
// s_axis   in   s_axis_tvalid/s_axis_tready    tdata: size, address, write_data, timer_value
//                                              tuser: mode
// m_axis   out  m_axis_tvalid/m_axis_tready    tdata: read_data; tuser: claimed, unimplemented
//
// One transaction per cycle while the result side is not stalled; an accepted
// transaction passes from the input register into the result register. Register
// writes take effect when the transaction moves into the result register, so the following transaction sees them.
// Reset clears the stored registers and both valid flags.
// A stalled result holds the input register, which then holds s_axis_tready low.
`default_nettype none
module pci_pm_function_config_space_core
    import pcipm_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [87:0] s_axis_tdata,  // size[1:0], address[17:2], write_data[49:18],
                                            // timer_value[81:50], zero fill
    input  wire logic [1:0]  s_axis_tuser,  // mode[1:0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,  // read_data[31:0]
    output logic [1:0]       m_axis_tuser   // claimed[0], unimplemented[1]
);

    logic        r_in_valid;
    logic [1:0]  r_mode;
    logic [1:0]  r_size;
    logic [15:0] r_address;
    logic [31:0] r_write_data;
    logic [31:0] r_timer_value;
    logic        r_out_valid;
    logic [31:0] r_read_data;
    logic        r_claimed;
    logic        r_unimpl;

    logic        n_read_data_valid;
    logic        advance;
    logic [31:0] dec_read_data;
    logic        dec_claimed;
    logic        dec_unimpl;
    t_reg_wr     dec_wr;
    t_reg_state  reg_state;

    assign advance           = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready     = !r_in_valid || advance;
    assign n_read_data_valid = advance || (r_out_valid && !m_axis_tready);

    pcipm_decode u_decode (
        .i_mode          (r_mode),
        .i_size          (r_size),
        .i_address       (r_address),
        .i_write_data    (r_write_data),
        .i_timer_value   (r_timer_value),
        .i_state         (reg_state),
        .o_read_data     (dec_read_data),
        .o_claimed       (dec_claimed),
        .o_unimplemented (dec_unimpl),
        .o_wr            (dec_wr)
    );

    pcipm_regs u_regs (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_commit (advance),
        .i_wr     (dec_wr),
        .o_state  (reg_state)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_axis_tready) r_in_valid <= s_axis_tvalid;
            r_out_valid <= n_read_data_valid;
        end
        if (s_axis_tready && s_axis_tvalid) begin
            r_mode        <= s_axis_tuser;
            r_size        <= s_axis_tdata[1:0];
            r_address     <= s_axis_tdata[17:2];
            r_write_data  <= s_axis_tdata[49:18];
            r_timer_value <= s_axis_tdata[81:50];
        end
        if (advance) begin
            r_read_data <= dec_read_data;
            r_claimed   <= dec_claimed;
            r_unimpl    <= dec_unimpl;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_read_data;
    assign m_axis_tuser  = {r_unimpl, r_claimed};

endmodule
`default_nettype wire

// File: rtl/core/pcipm_checker.sv
// Port-level checker for the PM function configuration space, bound to the top level.
`default_nettype none
module pcipm_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [31:0] m_axis_tdata,
    input wire logic [1:0]  m_axis_tuser
);

    // Drop the result register after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // Hold a stalled result
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // An unclaimed port reads zero and is not flagged
    a_unclaimed_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == 32'h0 && !m_axis_tuser[1])
        else $error("unclaimed access returned data or flag");

    // With the result register empty the input side must be open
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty result register");

endmodule

bind pci_pm_function_config_space_core pcipm_checker u_pcipm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire

// File: test/pci_pm_function_config_space_core_check.sv
`timescale 1ns / 1ps
// Scoreboard for the PM function config space: models header reads, masked writes and io decode.
module pci_pm_function_config_space_core_check
    import pcipm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [87:0] i_s_tdata,  // size[1:0], address[17:2], write_data[49:18],
                                    // timer_value[81:50], zero fill
    input  logic [1:0]  i_s_tuser,  // mode[1:0]
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [31:0] i_m_tdata,  // read_data[31:0]
    input  logic [1:0]  i_m_tuser,  // claimed[0], unimplemented[1]
    output int          o_fail_count,
    output int          o_pending
);

    localparam logic [7:0] A8_DEVICE_HI  = 8'h03;
    localparam logic [7:0] A8_CLASS_SUB  = 8'h0A;
    localparam logic [7:0] A8_CLASS_BASE = 8'h0B;
    localparam logic [7:0] A16_VENDOR    = 8'h00;
    localparam logic [7:0] A16_DEVICE    = 8'h01;
    localparam logic [7:0] A16_STATUS    = 8'h04;
    localparam logic [7:0] A16_CLASS     = 8'h05;
    localparam logic [7:0] A32_ID        = 8'h00;
    localparam logic [7:0] A32_CLASS     = 8'h02;

    typedef struct packed {
        logic [31:0] read_data;
        logic        claimed;
        logic        unimpl;
    } t_access_result;

    logic [15:0] cmd_q;
    logic [7:0]  int_line_q;
    logic        pm_en_q;
    logic [15:0] pm_base_q;
    logic [15:0] smb_base_q;
    logic [7:0]  smb_hcfg_q;

    t_access_result results_due[$];
    t_access_result got;
    t_access_result want;
    int mismatch_count = 0;

    assign o_fail_count = mismatch_count;

    function automatic t_access_result header_read(logic [1:0] sz, logic [7:0] a);
        t_access_result r;
        logic [15:0] id;
        r = '{read_data: 32'd0, claimed: 1'b1, unimpl: 1'b0};
        if (sz == SIZE_BYTE) begin
            id = a[1] ? DEVICE_ID : VENDOR_ID;
            if (a <= A8_DEVICE_HI) r.read_data = {24'd0, a[0] ? id[15:8] : id[7:0]};
            else if (a == 8'h08 || a == 8'h09 || a == 8'h0E) r.read_data = 32'd0;
            else if (a == A8_CLASS_SUB) r.read_data = {24'd0, CLASS_SUB};
            else if (a == A8_CLASS_BASE) r.read_data = {24'd0, CLASS_BASE};
            else if (a >= 8'h0F && a <= 8'h3B) r.read_data = 32'd0;
            else if (a == A8_INT_LINE) r.read_data = {24'd0, int_line_q};
            else if (a == A8_INT_PIN) r.read_data = {24'd0, INT_PIN};
            else if (a == A8_PM_EN) r.read_data = {31'd0, pm_en_q};
            else if (a == A8_SMB_HCFG) r.read_data = {24'd0, smb_hcfg_q};
            else begin
                r.read_data = 32'h0000_00FF;
                r.unimpl = 1'b1;
            end
        end else if (sz == SIZE_HALF) begin
            if (a == A16_VENDOR) r.read_data = {16'd0, VENDOR_ID};
            else if (a == A16_DEVICE) r.read_data = {16'd0, DEVICE_ID};
            else if (a == A16_COMMAND) r.read_data = {16'd0, cmd_q};
            else if (a == A16_STATUS) r.read_data = 32'd0;
            else if (a == A16_CLASS) r.read_data = {16'd0, CLASS_BASE, CLASS_SUB};
            else if (a >= 8'h08 && a <= 8'h1D) r.read_data = 32'd0;
            else begin
                r.read_data = 32'h0000_FFFF;
                r.unimpl = 1'b1;
            end
        end else begin
            if (a == A32_ID) r.read_data = {DEVICE_ID, VENDOR_ID};
            else if (a == A32_CLASS) r.read_data = {CLASS_BASE, CLASS_SUB, 16'd0};
            else if (a >= 8'h04 && a <= 8'h0E) r.read_data = 32'd0;
            else if (a == A32_PM_BASE) r.read_data = {16'd0, pm_base_q | 16'd1};
            else if (a == A32_SMB_BASE) r.read_data = {16'd0, smb_base_q | 16'd1};
            else begin
                r.read_data = 32'hFFFF_FFFF;
                r.unimpl = 1'b1;
            end
        end
        return r;
    endfunction

    // Returns 1 when the index is not implemented for this width.
    function automatic logic header_write(logic [1:0] sz, logic [7:0] a, logic [31:0] wd);
        if (sz == SIZE_BYTE) begin
            if (a <= A8_DEVICE_HI || a == 8'h09 || a == A8_CLASS_SUB || a == A8_CLASS_BASE ||
                a == 8'h0E || (a >= 8'h0F && a <= 8'h3B) || a == A8_INT_PIN) return 1'b0;
            if (a == A8_INT_LINE) begin
                int_line_q = wd[7:0];
                return 1'b0;
            end
            if (a == A8_PM_EN) begin
                pm_en_q = wd[0];
                return 1'b0;
            end
            if (a == A8_SMB_HCFG) begin
                smb_hcfg_q = wd[7:0];
                return 1'b0;
            end
            return 1'b1;
        end else if (sz == SIZE_HALF) begin
            if (a == A16_VENDOR || a == A16_DEVICE || a == A16_CLASS ||
                (a >= 8'h08 && a <= 8'h1D)) return 1'b0;
            if (a == A16_COMMAND) begin
                cmd_q = wd[15:0] & CMD_MASK;
                return 1'b0;
            end
            return 1'b1;
        end
        if (a == A32_ID || (a >= 8'h04 && a <= 8'h0E)) return 1'b0;
        if (a == A32_PM_BASE) begin
            pm_base_q = wd[15:0] & PMBA_MASK;
            return 1'b0;
        end
        if (a == A32_SMB_BASE) begin
            smb_base_q = wd[15:0] & SMBBA_MASK;
            return 1'b0;
        end
        return 1'b1;
    endfunction

    // Work out one access against the shadow registers, updating them on writes.
    function automatic t_access_result config_space_access(t_mode mode, logic [1:0] size,
            logic [15:0] addr, logic [31:0] wd, logic [31:0] timer);
        t_access_result r;
        logic [1:0]  sz;
        logic [16:0] port;
        r = '{read_data: 32'd0, claimed: 1'b0, unimpl: 1'b0};
        sz = (size == SIZE_ALT) ? SIZE_WORD : size;
        port = {1'b0, addr};
        if (mode == MODE_CFG_RD || mode == MODE_CFG_WR) begin
            r.claimed = 1'b1;
            if (addr[15:8] != 8'd0) begin
                r.unimpl = 1'b1;
                if (mode == MODE_CFG_RD)
                    r.read_data = (sz == SIZE_BYTE) ? 32'h0000_00FF :
                                  (sz == SIZE_HALF) ? 32'h0000_FFFF : 32'hFFFF_FFFF;
            end else if (mode == MODE_CFG_RD) begin
                r = header_read(sz, addr[7:0]);
            end else begin
                r.unimpl = header_write(sz, addr[7:0], wd);
            end
        end else if (pm_en_q && addr >= pm_base_q && port < {1'b0, pm_base_q} + PM_SPAN) begin
            r.claimed = 1'b1;
            if (mode == MODE_IO_RD && sz == SIZE_WORD && port - {1'b0, pm_base_q} == PMTMR_OFS)
                r.read_data = timer;
            else
                r.unimpl = 1'b1;
        end else if (cmd_q[0] && addr >= smb_base_q && port < {1'b0, smb_base_q} + SMB_SPAN) begin
            r.claimed = 1'b1;
            r.unimpl = 1'b1;
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cmd_q = '0;
            int_line_q = '0;
            pm_en_q = 1'b0;
            pm_base_q = '0;
            smb_base_q = '0;
            smb_hcfg_q = '0;
            results_due.delete();
            o_pending <= 0;
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got = '{read_data: i_m_tdata, claimed: i_m_tuser[0], unimpl: i_m_tuser[1]};
                if (results_due.size() == 0) begin
                    $display("%0t: result with none expected: read_data %h claimed %b unimpl %b",
                             $time, got.read_data, got.claimed, got.unimpl);
                    mismatch_count++;
                end else begin
                    want = results_due.pop_front();
                    if (got.read_data !== want.read_data) begin
                        $display("%0t: read_data expected %h actual %h",
                                 $time, want.read_data, got.read_data);
                        mismatch_count++;
                    end
                    if (got.claimed !== want.claimed) begin
                        $display("%0t: claimed expected %b actual %b",
                                 $time, want.claimed, got.claimed);
                        mismatch_count++;
                    end
                    if (got.unimpl !== want.unimpl) begin
                        $display("%0t: unimplemented expected %b actual %b",
                                 $time, want.unimpl, got.unimpl);
                        mismatch_count++;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready)
                results_due.push_back(config_space_access(t_mode'(i_s_tuser), i_s_tdata[1:0],
                    i_s_tdata[17:2], i_s_tdata[49:18], i_s_tdata[81:50]));
            o_pending <= results_due.size();
        end
    end

endmodule

// File: test/pci_pm_function_config_space_core_test.sv
`timescale 1ns / 1ps
// Top of the PM function config space bench: clock, reset, access stimulus and verdict.
module pci_pm_function_config_space_core_test;
    import pcipm_pkg::*;

    localparam int ITEM_COUNT     = 1700;
    localparam int IDLE_PCT       = 18;
    localparam int RX_HOLD_CYCLES = 200;
    localparam int STALL_LIMIT    = 4000;
    localparam int DRAIN_CYCLES   = 8;

    typedef struct packed {
        t_mode       mode;
        logic [1:0]  size;
        logic [15:0] address;
        logic [31:0] write_data;
        logic [31:0] timer_value;
    } t_access;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [87:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    int          fail_count;
    int          pending;
    int          stall_cycles = 0;

    logic        no_idle;
    logic        rx_hold_req;
    logic [15:0] pm_window;
    logic [15:0] smb_window;

    pci_pm_function_config_space_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    pci_pm_function_config_space_core_check u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_s_tuser    (s_axis_tuser),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .i_m_tuser    (m_axis_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic t_access mk(t_mode m, logic [1:0] sz, logic [15:0] a,
                                   logic [31:0] wd, logic [31:0] tm);
        t_access acc;
        acc.mode = m;
        acc.size = sz;
        acc.address = a;
        acc.write_data = wd;
        acc.timer_value = tm;
        return acc;
    endfunction

    // Mostly well-aimed accesses: window setup, header indexes, ports around the windows.
    function automatic t_access random_access();
        t_access     acc;
        int          pick;
        logic [15:0] base;
        pick = $urandom_range(99);
        acc.mode = t_mode'($urandom_range(3));
        acc.size = 2'($urandom_range(3));
        acc.address = 16'($urandom);
        acc.write_data = $urandom;
        acc.timer_value = $urandom;
        if (pick < 3) begin
            pm_window = 16'($urandom) & PMBA_MASK;
            acc.mode = MODE_CFG_WR;
            acc.size = SIZE_WORD;
            acc.address = {8'd0, A32_PM_BASE};
            acc.write_data[15:0] = pm_window | (acc.write_data[15:0] & ~PMBA_MASK);
        end else if (pick < 6) begin
            smb_window = 16'($urandom) & SMBBA_MASK;
            acc.mode = MODE_CFG_WR;
            acc.size = SIZE_WORD;
            acc.address = {8'd0, A32_SMB_BASE};
            acc.write_data[15:0] = smb_window | (acc.write_data[15:0] & ~SMBBA_MASK);
        end else if (pick < 7) begin
            acc.mode = MODE_CFG_WR;
            acc.size = SIZE_HALF;
            acc.address = {8'd0, A16_COMMAND};
            acc.write_data[0] = ($urandom_range(3) != 0);
        end else if (pick < 8) begin
            acc.mode = MODE_CFG_WR;
            acc.size = SIZE_BYTE;
            acc.address = {8'd0, A8_PM_EN};
            acc.write_data[0] = ($urandom_range(3) != 0);
        end else if (pick < 38) begin
            acc.mode = ($urandom_range(2) != 0) ? MODE_CFG_RD : MODE_CFG_WR;
            if ($urandom_range(19) != 0) begin
                case ($urandom_range(11))
                    0:       acc.address = {14'd0, 2'($urandom_range(3))};
                    1:       acc.address = {8'd0, A8_INT_LINE};
                    2:       acc.address = {8'd0, A8_INT_PIN};
                    3:       acc.address = {8'd0, A8_PM_EN};
                    4:       acc.address = {8'd0, A8_SMB_HCFG};
                    5:       acc.address = {8'd0, A16_COMMAND};
                    6:       acc.address = {8'd0, A32_PM_BASE};
                    7:       acc.address = {8'd0, A32_SMB_BASE};
                    8:       acc.address = 16'($urandom_range(4, 16'h0F));
                    9:       acc.address = 16'($urandom_range(16'h1C, 16'h3E));
                    default: acc.address = 16'($urandom_range(255));
                endcase
            end
        end else if (pick < 88) begin
            acc.mode = ($urandom_range(3) != 0) ? MODE_IO_RD : MODE_IO_WR;
            if ($urandom_range(2) == 0) begin
                acc.address = pm_window + PMTMR_OFS[15:0];
                acc.size = ($urandom_range(4) == 0) ? SIZE_ALT : SIZE_WORD;
            end else begin
                base = $urandom_range(1) ? pm_window : smb_window;
                acc.address = base + 16'($urandom_range(63)) - 16'd2;
            end
        end
        return acc;
    endfunction

    // Offer one transaction, with random gaps ahead of it, and hold it until taken.
    task automatic issue(input t_access acc);
        while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'd0, acc.timer_value, acc.write_data, acc.address, acc.size};
        s_axis_tuser  <= acc.mode;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    // Receiver: random backpressure, plus one long hold-off on request.
    initial begin
        int hold_left;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                for (hold_left = RX_HOLD_CYCLES; hold_left > 0; hold_left--) @(posedge i_clk);
            end else begin
                m_axis_tready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles == STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        int n;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= MODE_CFG_RD;
        no_idle     = 1'b0;
        rx_hold_req = 1'b0;
        pm_window   = 16'hFFC0;
        smb_window  = 16'hFFF0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // byte IDs, full IDs and class code, a byte index with no register behind it
        for (n = 0; n < 4; n++) issue(mk(MODE_CFG_RD, SIZE_BYTE, 16'(n), '0, '0));
        issue(mk(MODE_CFG_RD, SIZE_HALF, 16'h0000, '0, '0));
        issue(mk(MODE_CFG_RD, SIZE_WORD, 16'h0000, '0, '0));
        issue(mk(MODE_CFG_RD, SIZE_WORD, 16'h0002, '0, '0));
        issue(mk(MODE_CFG_RD, SIZE_BYTE, 16'h0004, '0, '0));
        // masked writes, mostly with all ones, read back; bases read with bit 0 set
        issue(mk(MODE_CFG_WR, SIZE_HALF, {8'd0, A16_COMMAND}, 32'hFFFF_FFFF, '0));
        issue(mk(MODE_CFG_RD, SIZE_HALF, {8'd0, A16_COMMAND}, '0, '0));
        issue(mk(MODE_CFG_WR, SIZE_BYTE, {8'd0, A8_INT_LINE}, 32'hFFFF_FFA5, '0));
        issue(mk(MODE_CFG_RD, SIZE_BYTE, {8'd0, A8_INT_LINE}, '0, '0));
        issue(mk(MODE_CFG_WR, SIZE_BYTE, {8'd0, A8_PM_EN}, 32'hFFFF_FFFF, '0));
        issue(mk(MODE_CFG_RD, SIZE_BYTE, {8'd0, A8_PM_EN}, '0, '0));
        issue(mk(MODE_CFG_WR, SIZE_WORD, {8'd0, A32_PM_BASE}, 32'hFFFF_FFFF, '0));
        issue(mk(MODE_CFG_RD, SIZE_WORD, {8'd0, A32_PM_BASE}, '0, '0));
        // size code three behaves as a word
        issue(mk(MODE_CFG_WR, SIZE_ALT, {8'd0, A32_SMB_BASE}, 32'hFFFF_FFFF, '0));
        issue(mk(MODE_CFG_RD, SIZE_ALT, {8'd0, A32_SMB_BASE}, '0, '0));
        // indexes above the header
        issue(mk(MODE_CFG_RD, SIZE_BYTE, 16'h0100, '0, '0));
        issue(mk(MODE_CFG_RD, SIZE_HALF, 16'hFFFF, '0, '0));
        issue(mk(MODE_CFG_WR, SIZE_WORD, 16'h8000, 32'hFFFF_FFFF, '0));
        // timer port, windows at the top of the io space without wrap
        issue(mk(MODE_IO_RD, SIZE_WORD, 16'hFFC8, '0, 32'hFFFF_FFFF));
        issue(mk(MODE_IO_RD, SIZE_ALT, 16'hFFC8, '0, 32'h5A5A_1234));
        issue(mk(MODE_IO_WR, SIZE_WORD, 16'hFFC8, 32'hFFFF_FFFF, 32'hA5A5_EDCB));
        issue(mk(MODE_IO_RD, SIZE_WORD, 16'hFFF8, '0, 32'hFFFF_FFFF));
        issue(mk(MODE_IO_RD, SIZE_BYTE, 16'hFFFF, '0, 32'hFFFF_FFFF));

        for (n = 0; n < ITEM_COUNT; n++) begin
            if (n == 300) rx_hold_req = 1'b1;
            if (n == 900) begin
                // let the pipe run dry before going on
                s_axis_tvalid <= 1'b0;
                @(posedge i_clk);
                while (pending != 0) @(posedge i_clk);
            end
            no_idle = (n >= 1100 && n < 1350);
            issue(random_access());
        end
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
